### design/glzw_pkg.sv
`default_nettype none
package glzw_pkg;
    localparam int TableDepth = 4096;
    localparam int MaxCodeBits = 12;
    localparam int CodeW = 12;
    localparam int AddrW = 3;
    localparam int DataW = 32;

    localparam logic [AddrW-1:0] RegMinCode = 3'd0;
    localparam logic [AddrW-1:0] RegLeft = 3'd1;
    localparam logic [AddrW-1:0] RegTop = 3'd2;
    localparam logic [AddrW-1:0] RegWidth = 3'd3;
    localparam logic [AddrW-1:0] RegHeight = 3'd4;
    localparam logic [AddrW-1:0] RegInterlaced = 3'd5;

    localparam logic CmdByte = 1'b0;
    localparam logic CmdTick = 1'b1;

    function automatic logic [3:0] root_bits(input logic [3:0] mcs);
        if (mcs < 4'd2) return 4'd2;
        if (mcs > 4'd8) return 4'd8;
        return mcs;
    endfunction

    function automatic logic [3:0] pass_start(input logic [1:0] p);
        case (p)
            2'd0: return 4'd0;
            2'd1: return 4'd4;
            2'd2: return 4'd2;
            default: return 4'd1;
        endcase
    endfunction

    function automatic logic [3:0] pass_step(input logic [1:0] p);
        case (p)
            2'd0: return 4'd8;
            2'd1: return 4'd8;
            2'd2: return 4'd4;
            default: return 4'd2;
        endcase
    endfunction
endpackage
`default_nettype wire

### design/gif_lzw_pixel_decoder.sv
// LZW pixel decoder for GIF image data. A request is either a stream byte
// (command 0, length bytes included) or a tick (command 1) that yields at most
// one pixel; every request gives exactly one result. Registers must be written
// over the APB port only while idle; the block does not enforce this. Every
// write to a defined register restarts the decoder. A byte's result is
// registered when the byte is taken. A tick that pops a stacked pixel goes
// through the pop and output states; a tick that decodes a code walks its
// string through the prefix/suffix memories (registered reads), one entry per
// cycle, then pops and outputs. A code equal to the next free entry first walks
// the previous string to find its first index. Clear, end and bad codes give
// their result from the decode state. Each pixel after the first of a string
// costs a pop tick. Tables hold no reset state.
`default_nettype none
module gif_lzw_pixel_decoder #(
    parameter int TABLE_DEPTH = glzw_pkg::TableDepth,
    parameter int MAX_CODE_BITS = glzw_pkg::MaxCodeBits
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [glzw_pkg::AddrW+1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_byte_taken,
    output logic             m_pixel_valid,
    output logic [7:0]       m_color_index,
    output logic [15:0]      m_pixel_x,
    output logic [15:0]      m_pixel_y,
    output logic             m_image_done,
    output logic             m_bad_code
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(MAX_CODE_BITS + 1);
    localparam logic [AW:0] DEPTH_L = (AW+1)'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0, S_WALK = 3'd1, S_FIRST = 3'd2,
                           S_POP = 3'd3, S_OUT = 3'd4, S_DEC = 3'd5;

    // config
    logic [3:0]  mcs_reg;
    logic [15:0] left_reg, top_reg, width_reg, height_reg;
    logic        ilace_reg;

    logic [AW-1:0] prefix_mem [TABLE_DEPTH];
    logic [7:0]    suffix_mem [TABLE_DEPTH];
    logic [7:0]    stack_mem  [TABLE_DEPTH];

    logic [2:0]  state_reg, state_next;
    logic [AW:0] sp_reg, sp_next;
    logic [19:0] bbuf_reg, bbuf_next;
    logic [4:0]  bcnt_reg, bcnt_next;
    logic [7:0]  left_bytes_reg, left_bytes_next;
    logic [CW-1:0] cw_reg, cw_next;
    logic [AW:0] nf_reg, nf_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic        havep_reg, havep_next, full_reg, full_next, fin_reg, fin_next;
    logic [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]  pass_reg, pass_next;

    // walk state
    logic [AW-1:0] walk_reg, walk_next, code_reg, code_next;
    logic        kwk_reg, kwk_next; // code equals next free
    logic [AW:0] guard_reg, guard_next;

    // result register
    logic        ov_reg, ov_next, ot_reg, ot_next, opv_reg, opv_next, obad_reg, obad_next;
    logic [7:0]  oc_reg, oc_next;
    logic [15:0] ox_reg, ox_next, oy_reg, oy_next;

    // memory ports
    logic          tw_en;
    logic [AW-1:0] tw_addr, tw_pre;
    logic [7:0]    tw_suf;
    logic [AW-1:0] tr_addr;
    logic [AW-1:0] pre_q;
    logic [7:0]    suf_q;
    logic          sw_en;
    logic [AW-1:0] sw_addr, sr_addr;
    logic [7:0]    sw_data, stk_q;

    always_ff @(posedge aclk) begin
        if (tw_en) begin
            prefix_mem[tw_addr] <= tw_pre;
            suffix_mem[tw_addr] <= tw_suf;
        end
        pre_q <= prefix_mem[tr_addr];
        suf_q <= suffix_mem[tr_addr];
        if (sw_en) stack_mem[sw_addr] <= sw_data;
        stk_q <= stack_mem[sr_addr];
    end

    logic cfg_wr;
    logic cfg_hit;
    logic [3:0] rb;
    logic [AW:0] roots;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_hit = cfg_wr &&
                     (paddr[glzw_pkg::AddrW+1:2] inside
                      {[glzw_pkg::RegMinCode:glzw_pkg::RegInterlaced]});
    assign rb = glzw_pkg::root_bits(mcs_reg);
    assign roots = (AW+1)'(1) << rb;

    always_comb begin
        case (paddr[glzw_pkg::AddrW+1:2])
            glzw_pkg::RegMinCode:    prdata = {28'd0, mcs_reg};
            glzw_pkg::RegLeft:       prdata = {16'd0, left_reg};
            glzw_pkg::RegTop:        prdata = {16'd0, top_reg};
            glzw_pkg::RegWidth:      prdata = {16'd0, width_reg};
            glzw_pkg::RegHeight:     prdata = {16'd0, height_reg};
            glzw_pkg::RegInterlaced: prdata = {31'd0, ilace_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    logic [3:0] rb_new;
    always_comb begin
        rb_new = rb;
        if (cfg_wr && paddr[glzw_pkg::AddrW+1:2] == glzw_pkg::RegMinCode)
            rb_new = glzw_pkg::root_bits(pwdata[3:0]);
    end

    logic [3:0]    rb_w;
    logic [AW:0]   nf_after;
    logic [AW-1:0] code_cur;
    logic [16:0]   nx;
    logic [17:0]   ny;
    logic [1:0]    pn;
    logic [3:0]    row;
    logic          found;

    always_comb begin
        state_next = state_reg;
        sp_next = sp_reg; bbuf_next = bbuf_reg; bcnt_next = bcnt_reg;
        left_bytes_next = left_bytes_reg; cw_next = cw_reg; nf_next = nf_reg;
        prev_next = prev_reg; havep_next = havep_reg; full_next = full_reg;
        fin_next = fin_reg; cx_next = cx_reg; cy_next = cy_reg; pass_next = pass_reg;
        walk_next = walk_reg; code_next = code_reg; kwk_next = kwk_reg;
        guard_next = guard_reg;
        ov_next = ov_reg; ot_next = ot_reg; opv_next = opv_reg; obad_next = obad_reg;
        oc_next = oc_reg; ox_next = ox_reg; oy_next = oy_reg;
        tw_en = 1'b0; tw_addr = nf_reg[AW-1:0]; tw_pre = prev_reg; tw_suf = 8'd0;
        tr_addr = walk_reg;
        sw_en = 1'b0; sw_addr = sp_reg[AW-1:0]; sw_data = suf_q;
        sr_addr = AW'(sp_reg - 1'b1);
        s_ready = 1'b0;
        rb_w = rb; nf_after = nf_reg; code_cur = '0;
        nx = '0; ny = '0; pn = pass_reg; row = '0; found = 1'b0;
        if (ov_reg && m_ready) ov_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = !ov_reg || m_ready;
                if (s_valid && s_ready) begin
                    ot_next = 1'b0; opv_next = 1'b0; obad_next = 1'b0;
                    oc_next = '0; ox_next = '0; oy_next = '0;
                    if (s_command == glzw_pkg::CmdByte) begin
                        ov_next = 1'b1;
                        if (left_bytes_reg == 8'd0) begin
                            left_bytes_next = s_data_byte; ot_next = 1'b1;
                        end else if (fin_reg) begin
                            left_bytes_next = left_bytes_reg - 1'b1; ot_next = 1'b1;
                        end else if (bcnt_reg <= 5'd12) begin
                            bbuf_next = bbuf_reg | (20'(s_data_byte) << bcnt_reg);
                            bcnt_next = bcnt_reg + 5'd8;
                            left_bytes_next = left_bytes_reg - 1'b1; ot_next = 1'b1;
                        end
                    end else if (sp_reg != '0) begin
                        state_next = S_POP;
                    end else if (!fin_reg && {1'b0, bcnt_reg} >= 6'(cw_reg)) begin
                        state_next = S_DEC;
                    end else begin
                        ov_next = 1'b1;
                    end
                end
            end
            S_DEC: begin
                code_cur = AW'(bbuf_reg & ((20'd1 << cw_reg) - 20'd1));
                bbuf_next = bbuf_reg >> cw_reg;
                bcnt_next = bcnt_reg - 5'(cw_reg);
                code_next = code_cur;
                guard_next = '0;
                if ({1'b0, code_cur} == roots) begin
                    cw_next = CW'(rb_w) + 1'b1; nf_next = roots + 2'd2;
                    havep_next = 1'b0; full_next = 1'b0;
                    ov_next = 1'b1; state_next = S_IDLE;
                end else if ({1'b0, code_cur} == roots + 1'b1) begin
                    fin_next = 1'b1; ov_next = 1'b1; state_next = S_IDLE;
                end else if ({1'b0, code_cur} < nf_reg) begin
                    kwk_next = 1'b0; walk_next = code_cur; tr_addr = code_cur;
                    state_next = S_WALK;
                end else if ({1'b0, code_cur} == nf_reg && havep_reg && !full_reg) begin
                    // previous string plus its first index; first walk finds the index
                    kwk_next = 1'b1; walk_next = prev_reg; tr_addr = prev_reg;
                    state_next = S_FIRST;
                end else begin
                    obad_next = 1'b1; ov_next = 1'b1; state_next = S_IDLE;
                end
            end
            S_FIRST: begin
                // follow prefix chain of previous code to find its first index
                if ({1'b0, walk_reg} >= roots && guard_reg < DEPTH_L) begin
                    walk_next = pre_q; tr_addr = pre_q; guard_next = guard_reg + 1'b1;
                end else begin
                    // push the first index as the deepest char of the new string
                    sw_en = 1'b1; sw_data = walk_reg[7:0];
                    sp_next = sp_reg + 1'b1;
                    tw_en = !full_reg && nf_reg < DEPTH_L;
                    tw_suf = walk_reg[7:0];
                    // the new code's chain continues at the previous code
                    walk_next = prev_reg; tr_addr = prev_reg; guard_next = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if ({1'b0, walk_reg} >= roots && guard_reg < DEPTH_L && sp_reg < DEPTH_L) begin
                    sw_en = 1'b1; sw_data = suf_q; sp_next = sp_reg + 1'b1;
                    walk_next = pre_q; tr_addr = pre_q; guard_next = guard_reg + 1'b1;
                end else begin
                    if (sp_reg < DEPTH_L) begin
                        sw_en = 1'b1; sw_data = walk_reg[7:0]; sp_next = sp_reg + 1'b1;
                    end
                    if (kwk_reg) begin
                        nf_after = nf_reg;
                    end else if (havep_reg && !full_reg && nf_reg < DEPTH_L) begin
                        tw_en = 1'b1; tw_suf = walk_reg[7:0];
                    end
                    if (kwk_reg ? (!full_reg && nf_reg < DEPTH_L)
                                : (havep_reg && !full_reg && nf_reg < DEPTH_L)) begin
                        nf_after = nf_reg + 1'b1;
                        nf_next = nf_after;
                        if (nf_after >= ((AW+1)'(1) << cw_reg) && cw_reg < CW'(MAX_CODE_BITS))
                            cw_next = cw_reg + 1'b1;
                        else if (nf_after >= DEPTH_L)
                            full_next = 1'b1;
                    end
                    prev_next = code_reg; havep_next = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP: begin
                // stack read address issued here, data next cycle
                sr_addr = AW'(sp_reg - 1'b1);
                sp_next = sp_reg - 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!ov_reg || m_ready) begin
                    ov_next = 1'b1; opv_next = 1'b1; oc_next = stk_q;
                    ox_next = cx_reg; oy_next = cy_reg;
                    state_next = S_IDLE;
                    nx = 17'(cx_reg) + 17'd1;
                    if (nx < 17'(left_reg) + 17'(width_reg) && !nx[16]) begin
                        cx_next = nx[15:0];
                    end else begin
                        cx_next = left_reg;
                        if (!ilace_reg) begin
                            cy_next = cy_reg + 16'd1;
                        end else begin
                            ny = 18'(cy_reg) + 18'(glzw_pkg::pass_step(pass_reg));
                            if (ny >= 18'(top_reg) + 18'(height_reg) && pass_reg < 2'd3) begin
                                for (int i = 1; i <= 3; i++) begin
                                    if (!found && 2'(i) > pass_reg) begin
                                        pn = 2'(i);
                                        row = glzw_pkg::pass_start(2'(i));
                                        if (16'(row) < height_reg) found = 1'b1;
                                    end
                                end
                                pass_next = pn;
                                ny = 18'(top_reg) + 18'(row);
                            end
                            cy_next = ny[15:0];
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_hit) begin
            sp_next = '0; bbuf_next = '0; bcnt_next = '0; left_bytes_next = '0;
            havep_next = 1'b0; full_next = 1'b0; prev_next = '0; pass_next = '0;
            fin_next = 1'b0;
            cw_next = CW'(rb_new) + 1'b1;
            nf_next = ((AW+1)'(1) << rb_new) + 2'd2;
            cx_next = (paddr[glzw_pkg::AddrW+1:2] == glzw_pkg::RegLeft) ?
                      pwdata[15:0] : left_reg;
            cy_next = (paddr[glzw_pkg::AddrW+1:2] == glzw_pkg::RegTop) ?
                      pwdata[15:0] : top_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcs_reg <= 4'd8; left_reg <= '0; top_reg <= '0;
            width_reg <= 16'd1; height_reg <= 16'd1; ilace_reg <= 1'b0;
            state_reg <= S_IDLE; sp_reg <= '0; bbuf_reg <= '0; bcnt_reg <= '0;
            left_bytes_reg <= '0; cw_reg <= CW'(9); nf_reg <= (AW+1)'(258);
            prev_reg <= '0; havep_reg <= 1'b0; full_reg <= 1'b0; fin_reg <= 1'b0;
            cx_reg <= '0; cy_reg <= '0; pass_reg <= '0; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next; sp_reg <= sp_next; bbuf_reg <= bbuf_next;
            bcnt_reg <= bcnt_next; left_bytes_reg <= left_bytes_next;
            cw_reg <= cw_next; nf_reg <= nf_next; prev_reg <= prev_next;
            havep_reg <= havep_next; full_reg <= full_next; fin_reg <= fin_next;
            cx_reg <= cx_next; cy_reg <= cy_next; pass_reg <= pass_next;
            ov_reg <= ov_next;
            if (cfg_wr) begin
                case (paddr[glzw_pkg::AddrW+1:2])
                    glzw_pkg::RegMinCode:    mcs_reg <= pwdata[3:0];
                    glzw_pkg::RegLeft:       left_reg <= pwdata[15:0];
                    glzw_pkg::RegTop:        top_reg <= pwdata[15:0];
                    glzw_pkg::RegWidth:      width_reg <= pwdata[15:0];
                    glzw_pkg::RegHeight:     height_reg <= pwdata[15:0];
                    glzw_pkg::RegInterlaced: ilace_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg <= walk_next; code_reg <= code_next; kwk_reg <= kwk_next;
        guard_reg <= guard_next;
        ot_reg <= ot_next; opv_reg <= opv_next; obad_reg <= obad_next;
        oc_reg <= oc_next; ox_reg <= ox_next; oy_reg <= oy_next;
    end

    assign m_valid = ov_reg;
    assign m_byte_taken = ot_reg;
    assign m_pixel_valid = opv_reg;
    assign m_color_index = oc_reg;
    assign m_pixel_x = ox_reg;
    assign m_pixel_y = oy_reg;
    assign m_image_done = fin_reg;
    assign m_bad_code = obad_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= DEPTH_L) else $error("stack overflow");
    a_nf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nf_reg <= DEPTH_L) else $error("next free beyond table");
    a_bcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= 5'd20) else $error("bit buffer overflow");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP |-> sp_reg != '0) else $error("pop from empty stack");
endmodule
`default_nettype wire
